>>> hdl/tga_pkg.sv
`default_nettype none
package tga_pkg;
    localparam int DimBits = 16;
    localparam int HdrLen = 18;
    localparam int QDepth = 2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_CMAP   = 3'd1;
    localparam logic [2:0] ST_TYPE   = 3'd2;
    localparam logic [2:0] ST_DEPTH  = 3'd3;
    localparam logic [2:0] ST_MISUSE = 3'd4;

    // Work handed from the front to the back part.
    typedef struct packed {
        logic                 is_pixel;
        logic [2:0]           status;
        logic [31:0]          pix;
        logic [DimBits-1:0]   col;
        logic [DimBits-1:0]   row;
        logic [2:0]           chans;
        logic                 last;
        logic                 pend;
    } t_job;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] col;
        logic [15:0] row;
        logic [2:0]  chans;
        logic        last;
        logic        pend;
        logic [2:0]  status;
    } t_res;
endpackage
`default_nettype wire

>>> hdl/tga_front.sv
`default_nettype none
module tga_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic         i_action,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_file_start,
    input  wire logic         i_stall,
    output tga_pkg::t_job     o_job,
    output logic              o_job_valid
);
    import tga_pkg::*;

    logic [4:0]         r_hpos;
    logic [7:0]         r_idskip;
    logic [1:0]         r_kind;
    logic [DimBits-1:0] r_w, r_h;
    logic [2:0]         r_chan;
    logic [1:0]         r_flip;
    logic [7:0]         r_pleft;
    logic               r_prun;
    logic [31:0]        r_pix;
    logic [1:0]         r_bip;
    logic [DimBits-1:0] r_col, r_row;
    logic [6:0]         r_rep;
    logic               r_fault;

    logic [4:0]         n_hpos;
    logic [7:0]         n_idskip;
    logic [1:0]         n_kind;
    logic [DimBits-1:0] n_w, n_h;
    logic [2:0]         n_chan;
    logic [1:0]         n_flip;
    logic [7:0]         n_pleft;
    logic               n_prun;
    logic [31:0]        n_pix;
    logic [1:0]         n_bip;
    logic [DimBits-1:0] n_col, n_row;
    logic [6:0]         n_rep;
    logic               n_fault;

    t_job job;
    logic job_v;
    logic take;
    logic emit;
    logic [15:0] dimv;
    logic [2:0]  cnt;
    logic [7:0]  pl_dec;

    function automatic logic [DimBits-1:0] sat(input logic [15:0] v);
        if (v > 16'((1 << DimBits) - 1)) return DimBits'((1 << DimBits) - 1);
        return DimBits'(v);
    endfunction

    assign take = i_push && !i_stall;

    always_comb begin
        n_hpos = r_hpos; n_idskip = r_idskip; n_kind = r_kind; n_w = r_w; n_h = r_h;
        n_chan = r_chan; n_flip = r_flip; n_pleft = r_pleft; n_prun = r_prun;
        n_pix = r_pix; n_bip = r_bip; n_col = r_col; n_row = r_row; n_rep = r_rep;
        n_fault = r_fault;
        job = '0;
        job_v = 1'b0;
        emit = 1'b0;
        dimv = 16'd0;
        cnt = 3'd0;
        pl_dec = 8'd0;
        if (i_action) begin
            if (r_rep == 7'd0) begin
                job_v = 1'b1; job.status = ST_MISUSE;
            end else begin
                n_rep = r_rep - 7'd1;
                emit = 1'b1;
            end
        end else begin
            if (i_file_start) begin
                n_hpos = '0; n_idskip = '0; n_kind = '0; n_w = '0; n_h = '0;
                n_chan = 3'd1; n_flip = '0; n_pleft = '0; n_prun = 1'b0;
                n_pix = '0; n_bip = '0; n_col = '0; n_row = '0; n_rep = '0;
                n_fault = 1'b0;
            end
            if (n_fault) begin
            end else if (n_rep != 7'd0) begin
                job_v = 1'b1; job.status = ST_MISUSE;
            end else if (n_hpos < 5'(HdrLen)) begin
                n_hpos = n_hpos + 5'd1;
                unique case (n_hpos - 5'd1)
                    5'd0: n_idskip = i_data_byte;
                    5'd1: if (i_data_byte != 8'd0) begin
                        n_fault = 1'b1; job_v = 1'b1; job.status = ST_CMAP;
                    end
                    5'd2: case (i_data_byte)
                        8'd2:  n_kind = 2'd0;
                        8'd3:  n_kind = 2'd2;
                        8'd10: n_kind = 2'd1;
                        8'd11: n_kind = 2'd3;
                        default: begin
                            n_fault = 1'b1; job_v = 1'b1; job.status = ST_TYPE;
                        end
                    endcase
                    5'd12: n_w = DimBits'(i_data_byte);
                    5'd13: begin
                        dimv = {i_data_byte, 8'(n_w)};
                        n_w = sat(dimv);
                    end
                    5'd14: n_h = DimBits'(i_data_byte);
                    5'd15: begin
                        dimv = {i_data_byte, 8'(n_h)};
                        n_h = sat(dimv);
                    end
                    5'd16: if (n_kind[1]) begin
                        if (i_data_byte != 8'd8) begin
                            n_fault = 1'b1; job_v = 1'b1; job.status = ST_DEPTH;
                        end else n_chan = 3'd1;
                    end else if (i_data_byte == 8'd24) n_chan = 3'd3;
                    else if (i_data_byte == 8'd32) n_chan = 3'd4;
                    else begin
                        n_fault = 1'b1; job_v = 1'b1; job.status = ST_DEPTH;
                    end
                    5'd17: n_flip = {i_data_byte[5], i_data_byte[4]};
                    default: ;
                endcase
            end else if (n_idskip != 8'd0) begin
                n_idskip = n_idskip - 8'd1;
            end else if (n_w == '0 || n_row >= n_h) begin
            end else if (n_kind[0] && n_pleft == 8'd0) begin
                n_prun = i_data_byte[7];
                n_pleft = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_bip = 2'd0;
            end else begin
                if (n_bip == 2'd0) n_pix = '0;
                n_pix[8*n_bip +: 8] = i_data_byte;
                cnt = {1'b0, n_bip} + 3'd1;
                if (cnt < n_chan) begin
                    n_bip = cnt[1:0];
                end else begin
                    n_bip = 2'd0;
                    if (n_kind[0]) begin
                        pl_dec = n_pleft - 8'd1;
                        n_pleft = pl_dec;
                        if (n_prun) begin
                            n_rep = pl_dec[6:0];
                            n_pleft = 8'd0;
                        end
                    end
                    emit = 1'b1;
                end
            end
        end
        if (emit) begin
            job_v = 1'b1;
            job.is_pixel = 1'b1;
            job.status = ST_OK;
            job.pix = n_pix;
            job.chans = n_chan;
            job.col = n_flip[0] ? (n_w - DimBits'(1) - n_col) : n_col;
            job.row = n_flip[1] ? n_row : (n_h - DimBits'(1) - n_row);
            job.last = (n_col + DimBits'(1) == n_w) && (n_row + DimBits'(1) == n_h);
            n_col = n_col + DimBits'(1);
            if (n_col >= n_w) begin
                n_col = '0;
                n_row = n_row + DimBits'(1);
            end
            if (n_w == '0 || n_row >= n_h) n_rep = '0;
        end
        job.pend = (n_rep != 7'd0);
        if (!emit) job.chans = n_chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos <= '0; r_idskip <= '0; r_kind <= '0; r_w <= '0; r_h <= '0;
            r_chan <= 3'd1; r_flip <= '0; r_pleft <= '0; r_prun <= 1'b0;
            r_pix <= '0; r_bip <= '0; r_col <= '0; r_row <= '0; r_rep <= '0;
            r_fault <= 1'b0;
        end else if (take) begin
            r_hpos <= n_hpos; r_idskip <= n_idskip; r_kind <= n_kind; r_w <= n_w;
            r_h <= n_h; r_chan <= n_chan; r_flip <= n_flip; r_pleft <= n_pleft;
            r_prun <= n_prun; r_pix <= n_pix; r_bip <= n_bip; r_col <= n_col;
            r_row <= n_row; r_rep <= n_rep; r_fault <= n_fault;
        end
    end

    assign o_job       = job;
    assign o_job_valid = take && job_v;
endmodule
`default_nettype wire

>>> hdl/tga_back.sv
`default_nettype none
module tga_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire tga_pkg::t_job i_job,
    input  wire logic      i_job_valid,
    output logic           o_full,
    output tga_pkg::t_res  o_res,
    output logic           o_empty,
    input  wire logic      i_pop
);
    import tga_pkg::*;

    t_res       r_mem [QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_res       res;
    logic       wr, rd;

    always_comb begin
        res = '0;
        res.status = i_job.status;
        res.chans = i_job.chans;
        res.pend = i_job.pend;
        if (i_job.is_pixel) begin
            res.col = 16'(i_job.col);
            res.row = 16'(i_job.row);
            res.last = i_job.last;
            if (i_job.chans == 3'd1) begin
                res.red = i_job.pix[7:0];
            end else begin
                res.red = i_job.pix[23:16];
                res.green = i_job.pix[15:8];
                res.blue = i_job.pix[7:0];
                res.alpha = (i_job.chans == 3'd4) ? i_job.pix[31:24] : 8'd0;
            end
        end
    end

    assign wr = i_job_valid;
    assign rd = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    assign o_res   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'(QDepth)) && !i_pop;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDepth))
        else $error("result queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count lost a write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("pointers differ on an empty queue");
endmodule
`default_nettype wire

>>> hdl/tga_image_stream_decoder.sv
`default_nettype none
// TGA stream decoder: one byte or drain word accepted per cycle while full is low.
// A result is visible (o_empty low) in the cycle after the word that causes it is accepted.
// Full rises only when both result slots hold
// results and pop is low.
// Reset (i_rst_n low, synchronous) clears the parser and empties the queue.
module tga_image_stream_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         i_action,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_file_start,
    output logic              empty,
    input  wire logic         pop,
    output logic [7:0]        o_comp_red,
    output logic [7:0]        o_comp_green,
    output logic [7:0]        o_comp_blue,
    output logic [7:0]        o_comp_alpha,
    output logic [15:0]       o_dest_col,
    output logic [15:0]       o_dest_row,
    output logic [2:0]        o_channel_count,
    output logic              o_last_pixel,
    output logic              o_run_pending,
    output logic [2:0]        o_status
);
    import tga_pkg::*;

    t_job job;
    logic job_valid;
    t_res res;

    // The parser updates its state in the cycle a word is accepted and
    // writes any result straight into the two-entry result queue.
    tga_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_action, .i_data_byte, .i_file_start,
        .i_stall(full), .o_job(job), .o_job_valid(job_valid)
    );

    tga_back u_back (
        .i_clk, .i_rst_n, .i_job(job), .i_job_valid(job_valid), .o_full(full),
        .o_res(res), .o_empty(empty), .i_pop(pop)
    );

    assign o_comp_red      = res.red;
    assign o_comp_green    = res.green;
    assign o_comp_blue     = res.blue;
    assign o_comp_alpha    = res.alpha;
    assign o_dest_col      = res.col;
    assign o_dest_row      = res.row;
    assign o_channel_count = res.chans;
    assign o_last_pixel    = res.last;
    assign o_run_pending   = res.pend;
    assign o_status        = res.status;
endmodule
`default_nettype wire

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_pkg::*;

    // Action codes of one input word.
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Image type codes in header byte 2.
    localparam logic [7:0] TYPE_RGB     = 8'd2;
    localparam logic [7:0] TYPE_GRAY    = 8'd3;
    localparam logic [7:0] TYPE_RGB_RLE = 8'd10;
    localparam logic [7:0] TYPE_GRAY_RLE = 8'd11;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1400;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [7:0]  i_data_byte;
    logic        i_file_start;
    logic        empty;
    logic        pop;
    logic [7:0]  o_comp_red;
    logic [7:0]  o_comp_green;
    logic [7:0]  o_comp_blue;
    logic [7:0]  o_comp_alpha;
    logic [15:0] o_dest_col;
    logic [15:0] o_dest_row;
    logic [2:0]  o_channel_count;
    logic        o_last_pixel;
    logic        o_run_pending;
    logic [2:0]  o_status;

    tga_image_stream_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_file_start    (i_file_start),
        .empty           (empty),
        .pop             (pop),
        .o_comp_red      (o_comp_red),
        .o_comp_green    (o_comp_green),
        .o_comp_blue     (o_comp_blue),
        .o_comp_alpha    (o_comp_alpha),
        .o_dest_col      (o_dest_col),
        .o_dest_row      (o_dest_row),
        .o_channel_count (o_channel_count),
        .o_last_pixel    (o_last_pixel),
        .o_run_pending   (o_run_pending),
        .o_status        (o_status)
    );

    // One word of stimulus, and one row of the directed table. When has_fixed
    // is set, the row also carries the result that must come out of it.
    typedef struct {
        logic        action;
        logic [7:0]  data;
        logic        start;
        logic        has_fixed;
        t_res        fixed;
    } t_word;

    // Decoder state as the predictor tracks it.
    logic [4:0]  hdr_pos;
    logic [7:0]  id_left;
    logic [1:0]  kind;        // bit 0 run coded, bit 1 gray
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [2:0]  chans_q;
    logic [1:0]  flips;       // bit 0 mirror, bit 1 top origin
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [31:0] pix_acc;
    logic [1:0]  pix_idx;
    logic [15:0] cur_col;
    logic [15:0] cur_row;
    logic [6:0]  reps_left;
    logic        fault_q;

    t_res  pending_pixels[$];
    t_word word_queue[$];
    int    mismatches;
    int    cycles;
    bit    calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_decoder();
        hdr_pos = '0; id_left = '0; kind = '0; width_q = '0; height_q = '0;
        chans_q = 3'd1; flips = '0; pkt_left = '0; pkt_run = 1'b0;
        pix_acc = '0; pix_idx = '0; cur_col = '0; cur_row = '0;
        reps_left = '0; fault_q = 1'b0;
    endtask

    function automatic bit picture_done();
        return width_q == 16'd0 || cur_row >= height_q;
    endfunction

    function automatic t_res status_word(logic [2:0] st);
        t_res r;
        r = '0;
        r.chans = chans_q;
        r.pend = reps_left != 0;
        r.status = st;
        return r;
    endfunction

    function automatic logic [15:0] sat16(logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    // Emits the pixel held in the accumulator and advances the position.
    task automatic emit_pixel(output t_res r);
        r = '0;
        r.col = flips[0] ? width_q - 16'd1 - cur_col : cur_col;
        r.row = flips[1] ? cur_row : height_q - 16'd1 - cur_row;
        r.last = ({1'b0, cur_col} + 17'd1 == {1'b0, width_q}) &&
                 ({1'b0, cur_row} + 17'd1 == {1'b0, height_q});
        if (chans_q == 3'd1) begin
            r.red = pix_acc[7:0];
        end else begin
            r.red = pix_acc[23:16];
            r.green = pix_acc[15:8];
            r.blue = pix_acc[7:0];
            r.alpha = (chans_q == 3'd4) ? pix_acc[31:24] : 8'd0;
        end
        cur_col = cur_col + 16'd1;
        if (cur_col >= width_q) begin
            cur_col = '0;
            cur_row = cur_row + 16'd1;
        end
        if (picture_done())
            reps_left = '0;
        r.chans = chans_q;
        r.pend = reps_left != 0;
        r.status = ST_OK;
    endtask

    // Header parsing; returns 1 when the byte yields an error result.
    task automatic take_header(input logic [7:0] v, output bit got, output t_res r);
        logic [4:0] pos;
        pos = hdr_pos;
        hdr_pos = hdr_pos + 5'd1;
        got = 1'b0;
        r = '0;
        case (pos)
            5'd0: id_left = v;
            5'd1: if (v != 8'd0) begin
                fault_q = 1'b1; got = 1'b1; r = status_word(ST_CMAP);
            end
            5'd2: begin
                if (v == TYPE_RGB) kind = 2'd0;
                else if (v == TYPE_GRAY) kind = 2'd2;
                else if (v == TYPE_RGB_RLE) kind = 2'd1;
                else if (v == TYPE_GRAY_RLE) kind = 2'd3;
                else begin
                    fault_q = 1'b1; got = 1'b1; r = status_word(ST_TYPE);
                end
            end
            5'd12: width_q = {8'd0, v};
            5'd13: width_q = sat16({1'b0, v, width_q[7:0]});
            5'd14: height_q = {8'd0, v};
            5'd15: height_q = sat16({1'b0, v, height_q[7:0]});
            5'd16: begin
                if (kind[1]) begin
                    if (v != 8'd8) begin
                        fault_q = 1'b1; got = 1'b1; r = status_word(ST_DEPTH);
                    end else begin
                        chans_q = 3'd1;
                    end
                end else if (v != 8'd24 && v != 8'd32) begin
                    fault_q = 1'b1; got = 1'b1; r = status_word(ST_DEPTH);
                end else begin
                    chans_q = v[5:3];
                end
            end
            5'd17: flips = {v[5], v[4]};
            default: ;
        endcase
    endtask

    // Full predictor step for one accepted word.
    task automatic decode_word(input t_word w, output bit got, output t_res r);
        logic [2:0] cnt;
        got = 1'b0;
        r = '0;
        if (w.action == ACT_DRAIN) begin
            got = 1'b1;
            if (reps_left == 0) begin
                r = status_word(ST_MISUSE);
            end else begin
                reps_left = reps_left - 7'd1;
                emit_pixel(r);
            end
            return;
        end
        if (w.start)
            clear_decoder();
        if (fault_q)
            return;
        if (reps_left != 0) begin
            got = 1'b1;
            r = status_word(ST_MISUSE);
            return;
        end
        if (hdr_pos < HdrLen) begin
            take_header(w.data, got, r);
            return;
        end
        if (id_left != 0) begin
            id_left = id_left - 8'd1;
            return;
        end
        if (picture_done())
            return;
        if (kind[0] && pkt_left == 0) begin
            pkt_run = w.data[7];
            pkt_left = {1'b0, w.data[6:0]} + 8'd1;
            pix_idx = '0;
            return;
        end
        if (pix_idx == 0)
            pix_acc = '0;
        pix_acc = pix_acc | ({24'd0, w.data} << (8 * pix_idx));
        cnt = {1'b0, pix_idx} + 3'd1;
        if (cnt < chans_q) begin
            pix_idx = cnt[1:0];
            return;
        end
        pix_idx = '0;
        if (kind[0]) begin
            pkt_left = pkt_left - 8'd1;
            if (pkt_run) begin
                reps_left = pkt_left[6:0];
                pkt_left = '0;
            end
        end
        got = 1'b1;
        emit_pixel(r);
    endtask

    function automatic t_word mk_word(logic act, logic [7:0] d, logic st);
        t_word w;
        w.action = act;
        w.data = d;
        w.start = st;
        w.has_fixed = 1'b0;
        w.fixed = '0;
        return w;
    endfunction

    function automatic t_word mk_fixed(logic act, logic [7:0] d, logic st, t_res r);
        t_word w;
        w = mk_word(act, d, st);
        w.has_fixed = 1'b1;
        w.fixed = r;
        return w;
    endfunction

    function automatic t_res fixed_status(logic [2:0] chans, logic [2:0] st);
        t_res r;
        r = '0;
        r.chans = chans;
        r.status = st;
        return r;
    endfunction

    // Queues an 18-byte header followed by the id field.
    task automatic queue_header(input logic [7:0] id_len, input logic [7:0] typ,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] depth, input logic [7:0] desc);
        logic [7:0] hdr[18];
        for (int k = 0; k < 18; k++)
            hdr[k] = 8'($urandom);
        hdr[0] = id_len;
        hdr[1] = 8'd0;
        hdr[2] = typ;
        hdr[12] = w[7:0];
        hdr[13] = w[15:8];
        hdr[14] = h[7:0];
        hdr[15] = h[15:8];
        hdr[16] = depth;
        hdr[17] = desc;
        for (int k = 0; k < 18; k++)
            word_queue.push_back(mk_word(ACT_BYTE, hdr[k], k == 0));
        for (int k = 0; k < id_len; k++)
            word_queue.push_back(mk_word(ACT_BYTE, 8'($urandom), 1'b0));
    endtask

    // A well-formed file with random content; runs are always drained in full,
    // and the body sometimes overruns the image.
    task automatic queue_random_file();
        logic [7:0] typ, depth;
        int nch, w, h, npix, left, n;
        bit rle;
        case ($urandom_range(3))
            0: typ = TYPE_RGB;
            1: typ = TYPE_GRAY;
            2: typ = TYPE_RGB_RLE;
            default: typ = TYPE_GRAY_RLE;
        endcase
        rle = typ[3];
        if (typ == TYPE_GRAY || typ == TYPE_GRAY_RLE) depth = 8'd8;
        else depth = $urandom_range(1) ? 8'd24 : 8'd32;
        nch = depth / 8;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        if ($urandom_range(19) == 0) w = 0;
        queue_header(8'($urandom_range(3)), typ, 16'(w), 16'(h), depth,
                     8'($urandom));
        npix = w * h + $urandom_range(2);
        left = npix;
        while (left > 0) begin
            if (rle) begin
                n = $urandom_range(1, 5);
                if (n > left) n = left;
                if ($urandom_range(1)) begin
                    word_queue.push_back(mk_word(ACT_BYTE, 8'(8'h80 | (n - 1)), 1'b0));
                    for (int k = 0; k < nch; k++)
                        word_queue.push_back(mk_word(ACT_BYTE, 8'($urandom), 1'b0));
                    for (int k = 1; k < n; k++)
                        word_queue.push_back(mk_word(ACT_DRAIN, 8'($urandom), 1'b0));
                end else begin
                    word_queue.push_back(mk_word(ACT_BYTE, 8'(n - 1), 1'b0));
                    for (int k = 0; k < n * nch; k++)
                        word_queue.push_back(mk_word(ACT_BYTE, 8'($urandom), 1'b0));
                end
            end else begin
                n = 1;
                for (int k = 0; k < nch; k++)
                    word_queue.push_back(mk_word(ACT_BYTE, 8'($urandom), 1'b0));
            end
            left -= n;
        end
    endtask

    // Noise: random bytes, random drains, broken headers.
    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            word_queue.push_back(mk_word(1'($urandom), 8'($urandom),
                                         $urandom_range(9) == 0));
    endtask

    task automatic report_mismatch(string msg);
        $display("error: %s", msg);
        mismatches++;
    endtask

    task automatic check_result(t_res got, t_res want);
        if (got.red != want.red)
            report_mismatch($sformatf("red got %0h expected %0h", got.red, want.red));
        if (got.green != want.green)
            report_mismatch($sformatf("green got %0h expected %0h", got.green, want.green));
        if (got.blue != want.blue)
            report_mismatch($sformatf("blue got %0h expected %0h", got.blue, want.blue));
        if (got.alpha != want.alpha)
            report_mismatch($sformatf("alpha got %0h expected %0h", got.alpha, want.alpha));
        if (got.col != want.col)
            report_mismatch($sformatf("col got %0h expected %0h", got.col, want.col));
        if (got.row != want.row)
            report_mismatch($sformatf("row got %0h expected %0h", got.row, want.row));
        if (got.chans != want.chans)
            report_mismatch($sformatf("chans got %0h expected %0h", got.chans, want.chans));
        if (got.last != want.last)
            report_mismatch($sformatf("last got %0h expected %0h", got.last, want.last));
        if (got.pend != want.pend)
            report_mismatch($sformatf("pend got %0h expected %0h", got.pend, want.pend));
        if (got.status != want.status)
            report_mismatch($sformatf("status got %0h expected %0h",
                                      got.status, want.status));
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tga_image_stream_decoder: mismatch");
            $finish;
        end
    end

    // Stretch with no idling on either side, around the middle of the run.
    always @(posedge i_clk)
        calm <= (cycles > 800 && cycles < 1300);

    // Result side: pop at random, check each popped result against the
    // oldest expected result.
    always @(posedge i_clk) begin
        t_res got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{o_comp_red, o_comp_green, o_comp_blue, o_comp_alpha,
                        o_dest_col, o_dest_row, o_channel_count, o_last_pixel,
                        o_run_pending, o_status};
                if (pending_pixels.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    check_result(got, pending_pixels.pop_front());
                end
            end
            pop <= calm || ($urandom_range(99) >= 25);
        end
    end

    // Stimulus side.
    initial begin
        t_word cur;
        t_res  want;
        bit    got;
        int    k;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_action = ACT_BYTE;
        i_data_byte = '0;
        i_file_start = 1'b0;
        mismatches = 0;
        cycles = 0;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Rows with a fixed result are the error codes and
        // misuse cases that can be read straight off the rules.
        word_queue.push_back(mk_fixed(ACT_DRAIN, 8'hFF, 1'b1,
                                      fixed_status(3'd1, ST_MISUSE)));
        word_queue.push_back(mk_word(ACT_BYTE, 8'h00, 1'b1));
        word_queue.push_back(mk_fixed(ACT_BYTE, 8'hFF, 1'b0,
                                      fixed_status(3'd1, ST_CMAP)));
        word_queue.push_back(mk_word(ACT_BYTE, 8'h55, 1'b0));   // ignored while faulted
        word_queue.push_back(mk_word(ACT_BYTE, 8'h00, 1'b1));
        word_queue.push_back(mk_word(ACT_BYTE, 8'h00, 1'b0));
        word_queue.push_back(mk_fixed(ACT_BYTE, 8'h01, 1'b0,
                                      fixed_status(3'd1, ST_TYPE)));
        // Gray type with a 24-bit depth.
        for (int j = 0; j < 16; j++)
            word_queue.push_back(mk_word(ACT_BYTE, j == 2 ? TYPE_GRAY : 8'h00, j == 0));
        word_queue.push_back(mk_fixed(ACT_BYTE, 8'd24, 1'b0,
                                      fixed_status(3'd1, ST_DEPTH)));
        // Saturated dimensions, mirror and top origin, one 32-bit run with a
        // byte sent while repeats are still pending, then a drain.
        queue_header(8'd1, TYPE_RGB_RLE, 16'hFFFF, 16'hFFFF, 8'd32, 8'h30);
        word_queue.push_back(mk_word(ACT_BYTE, 8'hFF, 1'b0));
        for (k = 0; k < 4; k++)
            word_queue.push_back(mk_word(ACT_BYTE, 8'(8'h10 * k + 8'hF), 1'b0));
        word_queue.push_back(mk_word(ACT_BYTE, 8'h00, 1'b0));
        word_queue.push_back(mk_word(ACT_DRAIN, 8'h00, 1'b0));
        // Empty image: every body byte is dropped.
        queue_header(8'd0, TYPE_GRAY, 16'd0, 16'd3, 8'd8, 8'h00);
        word_queue.push_back(mk_word(ACT_BYTE, 8'hAA, 1'b0));

        // Random part.
        while (word_queue.size() < RANDOM_WORDS + 60) begin
            if ($urandom_range(9) < 8) queue_random_file();
            else queue_noise();
        end

        while (word_queue.size() > 0) begin
            cur = word_queue.pop_front();
            if (!calm && $urandom_range(99) < 25) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (!calm && $urandom_range(99) < 25) @(posedge i_clk);
            end
            push <= 1'b1;
            i_action <= cur.action;
            i_data_byte <= cur.data;
            i_file_start <= cur.start;
            decode_word(cur, got, want);
            if (cur.has_fixed) begin
                if (!got)
                    report_mismatch("predictor gives no result for a fixed row");
                want = cur.fixed;
                got = 1'b1;
            end
            if (got)
                pending_pixels.push_back(want);
            @(posedge i_clk);
            while (full) @(posedge i_clk);
        end
        push <= 1'b0;

        while (pending_pixels.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tga_image_stream_decoder: match");
        else
            $display("tga_image_stream_decoder: mismatch");
        $finish;
    end
endmodule
